/* rtl/afrng_pkg.sv */
// ----------------------------------------------------------------------------
// afrng_pkg: shared types and constants of the additive-feedback generator
// Table geometry, seeding constants, operation codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package afrng_pkg;

  localparam int TABLE_DEGREE   = 31;
  localparam int TAP_SEPARATION = 3;
  localparam int WARMUP_DRAWS   = 310;

  localparam int IDX_W     = 5;
  localparam int WORD_W    = 32;
  localparam int VALUE_W   = 31;
  localparam int WU_W      = 10;
  localparam int REM_W     = 17;
  localparam int QUO_W     = 15;
  localparam int DIV_CNT_W = 2;
  localparam int DIV_STEPS = 2;
  localparam int PLO_W     = 32;
  localparam int PHI_W     = 27;
  localparam int PM_SHIFT  = 48;

  localparam logic [WORD_W-1:0] ZERO_SEED_SUB = 32'd123459876;
  localparam logic [REM_W-1:0]  PM_DIVISOR    = 17'd127773;
  localparam logic [QUO_W-1:0]  PM_MULT       = 15'd16807;
  localparam logic [11:0]       PM_CORR       = 12'd2836;
  localparam logic [WORD_W:0]   PM_MOD        = 33'h07fffffff;

  // Rounded-up reciprocal of the divisor, scaled by 2^PM_SHIFT.
  localparam logic [WORD_W-1:0] PM_RECIP =
    WORD_W'(((64'd1 << PM_SHIFT) + 64'(PM_DIVISOR) - 64'd1) / 64'(PM_DIVISOR));

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  typedef struct packed {
    logic rd_en;      // read the front and rear words
    logic draw_wr;    // write the sum back to the front word, advance indices
    logic out_load;   // capture the draw result in the output register
    logic seed_wr;    // write the seed into word 0
    logic pm_init;    // start a seeding step from the previous word
    logic pm_quo;     // form the quotient of the seeding division
    logic pm_rem;     // form the remainder of the seeding division
    logic pm_mul;     // form the two seeding products
    logic pm_wr;      // write the seeding result to the next word
    logic idx_reset;  // return the indices to their starting places
  } afrng_cmd_t;

  typedef struct packed {
    logic last_word;  // the seeding step writes the last table word
  } afrng_sts_t;

endpackage

/* rtl/afrng_ctrl.sv */
// ----------------------------------------------------------------------------
// afrng_ctrl: sequencer of the additive-feedback generator
// Takes requests, steps the datapath through draws, seeding steps and the
// warm-up draws, and owns the output valid flag.
// ----------------------------------------------------------------------------
module afrng_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tuser,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output afrng_pkg::afrng_cmd_t  cmd,
  input  afrng_pkg::afrng_sts_t  sts
);
  import afrng_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DRAW_WB = 3'd1;
  localparam logic [2:0] S_PM_INIT = 3'd2;
  localparam logic [2:0] S_PM_DIV  = 3'd3;
  localparam logic [2:0] S_PM_MUL  = 3'd4;
  localparam logic [2:0] S_PM_WR   = 3'd5;
  localparam logic [2:0] S_WU_RD   = 3'd6;
  localparam logic [2:0] S_WU_WB   = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [WU_W-1:0]      wu_cnt_r, wu_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    wu_cnt_nxt  = wu_cnt_r;
    cmd         = '0;
    in_tready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == OP_SEED) begin
            cmd.seed_wr = 1'b1;
            state_nxt   = S_PM_INIT;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = S_DRAW_WB;
          end
        end
      end
      S_DRAW_WB: begin
        // The read data waits here while the previous result is not taken.
        if (!out_valid_r || out_tready) begin
          cmd.draw_wr  = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_PM_INIT: begin
        cmd.pm_init = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = S_PM_DIV;
      end
      S_PM_DIV: begin
        // The quotient comes first, the remainder in the last step.
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          cmd.pm_rem = 1'b1;
          state_nxt  = S_PM_MUL;
        end else begin
          cmd.pm_quo = 1'b1;
        end
      end
      S_PM_MUL: begin
        cmd.pm_mul = 1'b1;
        state_nxt  = S_PM_WR;
      end
      S_PM_WR: begin
        cmd.pm_wr = 1'b1;
        if (sts.last_word) begin
          cmd.idx_reset = 1'b1;
          wu_cnt_nxt    = WU_W'(WARMUP_DRAWS);
          state_nxt     = (WARMUP_DRAWS == 0) ? S_IDLE : S_WU_RD;
        end else begin
          state_nxt = S_PM_INIT;
        end
      end
      S_WU_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WU_WB;
      end
      S_WU_WB: begin
        cmd.draw_wr = 1'b1;
        wu_cnt_nxt  = wu_cnt_r - 1'b1;
        state_nxt   = (wu_cnt_r == WU_W'(1)) ? S_IDLE : S_WU_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      wu_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      wu_cnt_r    <= wu_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten while waiting");

  // A reseed request leads straight into the seeding sequence.
  a_seed_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_SEED) |=> state_r == S_PM_INIT)
    else $error("reseed did not start seeding");

  // The division never runs past its step count.
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PM_DIV |-> div_cnt_r < DIV_CNT_W'(DIV_STEPS))
    else $error("division step count out of range");

  // A warm-up write-back always has draws left to count.
  a_wu_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WU_WB |-> wu_cnt_r != '0)
    else $error("warm-up counter underflow");

endmodule

/* rtl/afrng_dp.sv */
// ----------------------------------------------------------------------------
// afrng_dp: datapath of the additive-feedback generator
// Holds the feedback table, the two indices, the draw adder, the seeding
// divider and multipliers, and the output register.
// ----------------------------------------------------------------------------
module afrng_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  afrng_pkg::afrng_cmd_t           cmd,
  input  logic [afrng_pkg::WORD_W-1:0]    seed_in,
  output afrng_pkg::afrng_sts_t           sts,
  output logic [afrng_pkg::VALUE_W-1:0]   value_o
);
  import afrng_pkg::*;

  logic [WORD_W-1:0]       mem [TABLE_DEGREE];
  logic [TABLE_DEGREE-1:0] valid_r;
  logic [WORD_W-1:0]       rd_f_r, rd_r_r;
  logic [IDX_W-1:0]        f_r, r_r;
  logic [IDX_W-1:0]        seed_idx_r;
  logic [WORD_W-1:0]       x_r;
  logic                    neg_r;
  logic [WORD_W-1:0]       mag_r;
  logic [REM_W-1:0]        rem_r;
  logic [QUO_W-1:0]        q_r;
  logic [PLO_W-1:0]        p_lo_r;
  logic [PHI_W-1:0]        p_hi_r;
  logic [VALUE_W-1:0]      value_r;

  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [WORD_W-1:0]       wr_data;
  logic [WORD_W-1:0]       sum;
  logic [WORD_W-1:0]       xs, mag;
  logic [2*WORD_W-1:0]     quo_prod;
  logic [WORD_W-1:0]       rem_full;
  logic signed [WORD_W:0]  diff, sgn, adj;
  logic [WORD_W-1:0]       pm_res;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(TABLE_DEGREE - 1)) ? '0 : i + 1'b1;
  endfunction

  assign sum = rd_f_r + rd_r_r;

  // Seeding step: the zero substitute, then the magnitude for the division.
  assign xs  = (x_r == '0) ? ZERO_SEED_SUB : x_r;
  assign mag = xs[WORD_W-1] ? (~xs + 1'b1) : xs;

  // Division by the Park-Miller quotient constant through its reciprocal.
  // The magnitude never exceeds 2^31, and over that range the rounded-up
  // reciprocal with this shift gives the exact quotient. The remainder
  // follows from the registered quotient by multiply and subtract.
  assign quo_prod = (2*WORD_W)'(mag_r) * (2*WORD_W)'(PM_RECIP);
  assign rem_full = mag_r - WORD_W'(q_r) * WORD_W'(PM_DIVISOR);

  // Truncating signed division gives both quotient and remainder the sign
  // of the dividend, so the whole difference simply takes that sign.
  assign diff   = $signed({1'b0, p_lo_r}) - $signed({6'b0, p_hi_r});
  assign sgn    = neg_r ? -diff : diff;
  assign adj    = sgn[WORD_W] ? sgn + $signed(PM_MOD) : sgn;
  assign pm_res = adj[WORD_W-1:0];

  assign sts.last_word = (seed_idx_r == IDX_W'(TABLE_DEGREE - 1));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = f_r;
    wr_data = sum;
    if (cmd.draw_wr) begin
      wr_en = 1'b1;
    end else if (cmd.seed_wr) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = seed_in;
    end else if (cmd.pm_wr) begin
      wr_en   = 1'b1;
      wr_addr = seed_idx_r;
      wr_data = pm_res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_f_r <= valid_r[f_r] ? mem[f_r] : '0;
      rd_r_r <= valid_r[r_r] ? mem[r_r] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      f_r     <= IDX_W'(TAP_SEPARATION);
      r_r     <= '0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.idx_reset) begin
        f_r <= IDX_W'(TAP_SEPARATION);
        r_r <= '0;
      end else if (cmd.draw_wr) begin
        f_r <= idx_inc(f_r);
        r_r <= idx_inc(r_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_wr) begin
      x_r        <= seed_in;
      seed_idx_r <= IDX_W'(1);
    end else if (cmd.pm_wr) begin
      x_r        <= pm_res;
      seed_idx_r <= seed_idx_r + 1'b1;
    end
    if (cmd.pm_init) begin
      neg_r <= xs[WORD_W-1];
      mag_r <= mag;
    end
    if (cmd.pm_quo) begin
      q_r <= quo_prod[PM_SHIFT+QUO_W-1:PM_SHIFT];
    end
    if (cmd.pm_rem) begin
      rem_r <= rem_full[REM_W-1:0];
    end
    if (cmd.pm_mul) begin
      p_lo_r <= PLO_W'(rem_r) * PLO_W'(PM_MULT);
      p_hi_r <= PHI_W'(q_r) * PHI_W'(PM_CORR);
    end
    if (cmd.out_load) begin
      value_r <= sum[WORD_W-1:1];
    end
  end

  assign value_o = value_r;

endmodule

/* rtl/additive_feedback_rng.sv */
// ----------------------------------------------------------------------------
// additive_feedback_rng: lagged additive-feedback random number generator
// A 31-word table with taps three apart; each draw adds the rear word into
// the front word and returns its top 31 bits. A reseed refills the table
// through a Park-Miller sequence and runs the warm-up draws.
// ----------------------------------------------------------------------------
//
//   Channel | Ports       | Payload
//   --------+-------------+----------------------------------------------
//   in      | in_t*       | tuser: opcode (0 draw, 1 reseed); tdata: seed
//   out     | out_t*      | tdata[30:0]: value, tdata[31] zero
//
// A draw reads the front and rear words, then writes the sum back and
// loads the output register. A reseed writes the seed into word 0, then
// fills the other 30 words in turn (each word takes an operand step, a
// division by reciprocal multiplication in a quotient step and a
// remainder step, a multiply step and a write step), then runs 310
// warm-up draws; no request is taken until the reseed ends.
// Reset clears the table to zeros through per-word valid bits, so draws
// return zero until the first reseed. A stalled output holds a draw in its
// write-back cycle; reseed requests are still taken while a result waits.
//
module additive_feedback_rng (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [30:0] value, [31] zero fill
);
  import afrng_pkg::*;

  afrng_cmd_t         cmd;
  afrng_sts_t         sts;
  logic [VALUE_W-1:0] value;

  // The controller sequences requests; the datapath holds all the words.
  afrng_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  afrng_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .seed_in (in_tdata),
    .sts     (sts),
    .value_o (value)
  );

  // The result is 31 bits wide; the top bit of the byte-aligned bus is zero.
  assign out_tdata = {1'b0, value};

endmodule
